// ----- rtl/krs_pkg.sv -----
// ----------------------------------------------------------------------------
// krs_pkg
// Shared types, widths and the reciprocal table of the key-player reach
// score block.
// ----------------------------------------------------------------------------
package krs_pkg;

    localparam int DIST_W     = 8;
    localparam int IDX_W      = 8;
    localparam int NC_W       = 9;
    localparam int FRAC_BITS  = 16;
    localparam int RECIP_W    = FRAC_BITS + 1;
    localparam int SUM_W      = 25;
    localparam int SCORE_W    = 17;
    localparam int MAX_NODES  = 256;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int RECIP_DEPTH = 1 << DIST_W;

    localparam logic [NC_W-1:0] NC_RESET =
        NC_W'((MAX_NODES > 511) ? 511 : MAX_NODES);

    // input word
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              unreachable;
        logic [IDX_W-1:0]  node;
        logic [IDX_W-1:0]  member;
        logic              last_member;
        logic              last_node;
    } item_t;

    // result word
    typedef struct packed {
        logic [IDX_W-1:0]   result_node;
        logic [IDX_W-1:0]   nearest_member;
        logic               nearest_found;
        logic [DIST_W-1:0]  nearest_distance;
        logic [SCORE_W-1:0] score;
        logic               score_valid;
    } result_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_ADD,
        ST_DLOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic recip_load;
        logic sum_add;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic item_last_member;
        logic last_node;
        logic div_last;
        logic out_free;
    } status_t;

    // reciprocal table: floor(2^FRAC_BITS / d), zero for d = 0
    typedef logic [RECIP_W-1:0] recip_table_t [RECIP_DEPTH];

    function automatic recip_table_t build_recip();
        recip_table_t       t;
        logic [RECIP_W:0]   rem;
        logic [RECIP_W-1:0] quo;
        t[0] = '0;
        for (int i = 1; i < RECIP_DEPTH; i++)
        begin
            rem = '0;
            quo = '0;
            // long division of 2^FRAC_BITS, one quotient bit per step
            for (int b = FRAC_BITS; b >= 0; b--)
            begin
                rem = {rem[RECIP_W-1:0], (b == FRAC_BITS)};
                if (rem >= (RECIP_W+1)'(i))
                begin
                    rem = rem - (RECIP_W+1)'(i);
                    quo = {quo[RECIP_W-2:0], 1'b1};
                end
                else
                begin
                    quo = {quo[RECIP_W-2:0], 1'b0};
                end
            end
            t[i] = quo;
        end
        return t;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip();

endpackage

// ----- rtl/key_player_reach_score.sv -----
// ----------------------------------------------------------------------------
// key_player_reach_score
// Distance-weighted reach of a key-player set, with nearest member per node.
// ----------------------------------------------------------------------------
// While the block is idle, one word per cycle is taken for every item that
// does not close a node. An item with last_member closes the node and runs
// accept, reciprocal table register, saturating add and result load; with
// last_node, a bit-serial restoring divider (one load, then one quotient bit
// per cycle over the 25-bit sum) comes before the result load. The closing
// load waits while the previous result is still held by a stall. cfg_ready
// is always high; write node_count only while the block is idle.
module key_player_reach_score (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  krs_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output krs_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [krs_pkg::NC_W-1:0]   cfg_data
);
    import krs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // accept configuration at any time
    assign cfg_ready = 1'b1;

    // sequence the work
    krs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // compute
    krs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // closing word blocks the next one
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.last_member) |=> item_stall)
        else $error("input not stalled after closing word");

    // non-final results carry no score
    a_score_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.score_valid) |-> (result.score == '0))
        else $error("score set on non-final result");

    // no nearest member means zero fields
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.nearest_found) |->
        ((result.nearest_member == '0) && (result.nearest_distance == '0)))
        else $error("nearest fields set with nothing found");

    // a held result does not get overwritten
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

// ----- rtl/krs_ctrl.sv -----
// ----------------------------------------------------------------------------
// krs_ctrl
// Sequencer: takes words, steps the reciprocal add, the serial divide and
// the result load.
// ----------------------------------------------------------------------------
module krs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  krs_pkg::status_t  status,
    output krs_pkg::cmd_t     cmd
);
    import krs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.item_last_member)
                    begin
                        state_next = ST_RECIP;
                    end
                end
            end
            ST_RECIP:
            begin
                cmd.recip_load = 1'b1;
                state_next     = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.sum_add = 1'b1;
                state_next  = status.last_node ? ST_DLOAD : ST_FIN;
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/krs_dp.sv -----
// ----------------------------------------------------------------------------
// krs_dp
// Datapath: running minimum, reciprocal sum, bit-serial divider and the
// result register.
// ----------------------------------------------------------------------------
module krs_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  krs_pkg::item_t                 item,
    input  logic                           cfg_valid,
    input  logic [krs_pkg::NC_W-1:0]       cfg_data,
    input  krs_pkg::cmd_t                  cmd,
    output krs_pkg::status_t               status,
    output logic                           result_valid,
    input  logic                           result_stall,
    output krs_pkg::result_t               result
);
    import krs_pkg::*;

    logic [NC_W-1:0]      node_count_reg;
    logic [DIST_W-1:0]    min_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_reg;
    logic [IDX_W-1:0]     node_reg;
    logic                 last_node_reg;
    logic [RECIP_W-1:0]   recip_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [SUM_W-1:0]     quot_reg;
    logic [NC_W-1:0]      rem_reg;
    logic [NC_W-1:0]      divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 result_valid_reg;
    result_t              result_reg;

    logic                 take_min;
    logic [SUM_W:0]       sum_wide;
    logic [NC_W:0]        rem_shift;
    logic [NC_W:0]        rem_diff;
    logic                 q_bit;
    logic [SCORE_W-1:0]   score_sat;

    // strict minimum over finite distances
    assign take_min = !item.unreachable && (!found_reg || (item.distance < min_reg));

    // saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(recip_reg);
    assign sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // one restoring divide step
    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign q_bit     = (rem_shift >= {1'b0, divisor_reg});

    // clamp quotient to score width
    assign score_sat = (|quot_reg[SUM_W-1:SCORE_W]) ? {SCORE_W{1'b1}}
                                                    : quot_reg[SCORE_W-1:0];

    // report status
    assign status.item_last_member = item.last_member;
    assign status.last_node        = last_node_reg;
    assign status.div_last         = (cnt_reg == DIV_CNT_W'(SUM_W - 1));
    assign status.out_free         = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= NC_RESET;
            min_reg          <= {DIST_W{1'b1}};
            found_reg        <= 1'b0;
            best_reg         <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // write configuration
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
            // track nearest member
            if (cmd.accept && take_min)
            begin
                min_reg   <= item.distance;
                best_reg  <= item.member;
                found_reg <= 1'b1;
            end
            else if (cmd.out_load)
            begin
                min_reg   <= {DIST_W{1'b1}};
                best_reg  <= '0;
                found_reg <= 1'b0;
            end
            // accumulate or clear the sum
            if (cmd.sum_add && found_reg)
            begin
                sum_reg <= sum_next;
            end
            else if (cmd.div_load)
            begin
                sum_reg <= '0;
            end
            // advance result handshake
            if (cmd.out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            node_reg      <= item.node;
            last_node_reg <= item.last_node;
        end
        if (cmd.recip_load)
        begin
            recip_reg <= RECIP_TABLE[min_reg];
        end
        if (cmd.div_load)
        begin
            quot_reg    <= sum_reg;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            divisor_reg <= (node_count_reg == '0) ? NC_W'(1) : node_count_reg;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], q_bit};
            rem_reg  <= q_bit ? rem_diff[NC_W-1:0] : rem_shift[NC_W-1:0];
            cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            result_reg.result_node      <= node_reg;
            result_reg.nearest_member   <= found_reg ? best_reg : '0;
            result_reg.nearest_found    <= found_reg;
            result_reg.nearest_distance <= found_reg ? min_reg : '0;
            result_reg.score            <= last_node_reg ? score_sat : '0;
            result_reg.score_valid      <= last_node_reg;
        end
    end

endmodule

// ----- bench/krs_reach_checker.sv -----
// ----------------------------------------------------------------------------
// krs_reach_checker
// Watches the item, result and node_count channels of key_player_reach_score,
// tracks the per-node minimum and the reciprocal sum on its own, and compares
// every accepted result word with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module krs_reach_checker
    import krs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  item_t            item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  result_t          result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [NC_W-1:0]  cfg_data,
    output int               fail_count,
    output int               waiting,
    output int               results_seen,
    output int               scores_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // shadow of the block's configuration and node state
    logic [NC_W-1:0]   node_count_q;
    logic [DIST_W-1:0] min_dist;
    bit                min_valid;
    logic [IDX_W-1:0]  min_member;
    logic [SUM_W-1:0]  reach_sum;

    result_t expected_results[$];

    // fold one distance into the node state; returns 1 when it closes a node
    function automatic bit absorb_distance(input item_t w, output result_t r);
        logic [SUM_W:0]   grown;
        logic [SUM_W-1:0] quotient;
        logic [NC_W-1:0]  divisor;
        r = '0;
        if (!w.unreachable && (!min_valid || w.distance < min_dist))
        begin
            min_dist   = w.distance;
            min_member = w.member;
            min_valid  = 1'b1;
        end
        if (!w.last_member)
            return 1'b0;

        // add the reciprocal of a finite nonzero minimum, saturating
        if (min_valid && min_dist != '0)
        begin
            grown = {1'b0, reach_sum} + ((SUM_W+1)'(1) << FRAC_BITS) / min_dist;
            reach_sum = (grown > {1'b0, SUM_MAX}) ? SUM_MAX : grown[SUM_W-1:0];
        end

        r.result_node      = w.node;
        r.nearest_member   = min_valid ? min_member : '0;
        r.nearest_found    = min_valid;
        r.nearest_distance = min_valid ? min_dist : '0;

        // finalize the graph score and restart the sum
        if (w.last_node)
        begin
            divisor       = (node_count_q == '0) ? NC_W'(1) : node_count_q;
            quotient      = reach_sum / divisor;
            r.score       = (quotient > SUM_W'(SCORE_MAX)) ? SCORE_MAX
                                                           : quotient[SCORE_W-1:0];
            r.score_valid = 1'b1;
            reach_sum     = '0;
        end

        min_dist   = '1;
        min_valid  = 1'b0;
        min_member = '0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            node_count_q = NC_RESET;
            min_dist     = '1;
            min_valid    = 1'b0;
            min_member   = '0;
            reach_sum    = '0;
            expected_results.delete();
            fail_count   = 0;
            results_seen = 0;
            scores_seen  = 0;
        end
        else
        begin
            // compare a delivered result word with the oldest prediction
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result word for node %0d with nothing expected",
                           result.result_node);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.score_valid)
                        scores_seen++;
                    check_field("result_node", want.result_node, result.result_node);
                    check_field("nearest_member", want.nearest_member,
                                result.nearest_member);
                    check_field("nearest_found", want.nearest_found,
                                result.nearest_found);
                    check_field("nearest_distance", want.nearest_distance,
                                result.nearest_distance);
                    check_field("score", want.score, result.score);
                    check_field("score_valid", want.score_valid, result.score_valid);
                end
            end

            if (cfg_valid && cfg_ready)
                node_count_q = cfg_data;

            // predict from an accepted item word
            if (item_valid && !item_stall)
            begin
                if (absorb_distance(item, fresh))
                    expected_results.push_back(fresh);
            end
        end
        waiting = expected_results.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives key_player_reach_score with directed node sequences and random
// graphs under several node_count settings, with random idling on both
// channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import krs_pkg::*;

    localparam int IDLE_PCT     = 38;
    localparam int HOLD_CYCLES  = 160;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS  = 60;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [NC_W-1:0]   cfg_data;

    int fail_count;
    int waiting;
    int results_seen;
    int scores_seen;

    int items_sent;
    int settings_used;
    bit calm;
    int holds_asked;
    int holds_granted;

    key_player_reach_score dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    krs_reach_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .waiting      (waiting),
        .results_seen (results_seen),
        .scores_seen  (scores_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_granted != holds_asked)
            begin
                holds_granted++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic item_t make_word(input logic [DIST_W-1:0] d, input bit unr,
                                        input logic [IDX_W-1:0] nd,
                                        input logic [IDX_W-1:0] mem,
                                        input bit lm, input bit ln);
        item_t w;
        w.distance    = d;
        w.unreachable = unr;
        w.node        = nd;
        w.member      = mem;
        w.last_member = lm;
        w.last_node   = ln;
        return w;
    endfunction

    // random member word, skewed toward ties, zero, 255 and unreachable
    function automatic item_t random_member(input logic [IDX_W-1:0] nd,
                                            input bit lm, input bit ln);
        item_t w;
        int pick;
        pick = $urandom_range(99);
        w = make_word(DIST_W'($urandom_range(255)), 1'b0, nd,
                      IDX_W'($urandom_range(255)), lm, ln);
        if (pick < 12)
            w.unreachable = 1'b1;
        else if (pick < 40)
            w.distance = DIST_W'($urandom_range(3));
        else if (pick < 45)
            w.distance = '1;
        return w;
    endfunction

    // offer one word after a random gap, hold it until taken
    task automatic send_word(input item_t w);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_node_count(input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_data  <= NC_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // drop valid, wait until every expected result has been delivered, then idle
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one graph: well-formed nodes with random content and some stray words
    task automatic send_graph(input int nodes);
        logic [IDX_W-1:0] nd;
        logic [31:0]      bits;
        int               members;
        bit               closes;
        bit               ln;
        nd     = IDX_W'($urandom_range(255));
        closes = $urandom_range(99) < 85;
        for (int n = 0; n < nodes; n++)
        begin
            members = ($urandom_range(9) == 0) ? $urandom_range(7, 16)
                                               : $urandom_range(1, 5);
            for (int m = 0; m < members; m++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    bits = $urandom();
                    send_word(bits[$bits(item_t)-1:0]);
                end
                ln = (closes && n == nodes - 1) || ($urandom_range(99) < 4);
                if (m == members - 1)
                    ln = closes && n == nodes - 1;
                send_word(random_member(nd, m == members - 1, ln));
            end
            nd++;
        end
    endtask

    // stimulus
    initial
    begin
        int unsigned settings[8];
        int          phase_end;
        rst_n         <= 1'b0;
        item_valid    <= 1'b0;
        item          <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        items_sent    = 0;
        settings_used = 0;
        calm          = 1'b0;
        holds_asked   = 0;
        holds_granted = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // strict minimum: the tie at 3 keeps member 20
        send_word(make_word(5, 0, 0, 10, 0, 0));
        send_word(make_word(3, 0, 0, 20, 0, 0));
        send_word(make_word(3, 0, 0, 30, 0, 0));
        send_word(make_word(7, 0, 0, 40, 1, 0));
        // no reachable member
        send_word(make_word(0, 1, 1, 0, 0, 0));
        send_word(make_word(255, 1, 1, 255, 1, 0));
        // a finite 255 is still a minimum
        send_word(make_word(0, 1, 2, 7, 0, 0));
        send_word(make_word(255, 0, 2, 255, 1, 0));
        // unreachable closing member keeps the earlier minimum
        send_word(make_word(9, 0, 3, 3, 0, 0));
        send_word(make_word(200, 1, 3, 4, 1, 0));
        // zero minimum adds nothing
        send_word(make_word(0, 0, 4, 0, 1, 0));
        // last_node without a close, then the graph end
        send_word(make_word(1, 0, 255, 5, 0, 1));
        send_word(make_word(2, 0, 255, 6, 1, 0));
        send_word(make_word(1, 0, 254, 1, 1, 1));
        settle();

        // score saturates with a single-node divisor
        write_node_count(1);
        for (int i = 0; i < 4; i++)
            send_word(make_word(1, 0, IDX_W'(10 + i), 1, 1, i == 3));
        settle();

        // zero divisor counts as one
        write_node_count(0);
        send_word(make_word(4, 0, 20, 9, 1, 1));
        send_word(make_word(0, 1, 21, 9, 1, 1));
        settle();

        // random graphs under a sweep of divisors
        settings[0] = 2;
        settings[1] = 256;
        settings[2] = 1;
        settings[3] = $urandom_range(1, 511);
        settings[4] = 511;
        settings[5] = 0;
        settings[6] = $urandom_range(3, 200);
        settings[7] = 3;
        for (int p = 0; p < 8; p++)
        begin
            write_node_count(settings[p]);
            calm = (p == 1);
            if (p == 4)
                holds_asked++;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_graph($urandom_range(1, 5));
            settle();
        end
        calm = 1'b0;

        $display("Sent %0d item words across %0d node_count settings;",
                 items_sent, settings_used);
        $display("checked %0d result words, %0d of them carrying a final score.",
                 results_seen, scores_seen);
        if (fail_count == 0 && waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/krs_pkg.sv
rtl/krs_ctrl.sv
rtl/krs_dp.sv
rtl/key_player_reach_score.sv
bench/krs_reach_checker.sv
bench/tb_top.sv
